// File: rtl/sm4_pkg.sv
`timescale 1ns / 1ps
// SM4 shared package: word types, register indexes, S-box and key constants,
// round functions. Used by every module of the block; depends on nothing.

package sm4_pkg;

	// Configuration register indexes
	localparam int CfgIdxW = 2;
	localparam logic [CfgIdxW-1:0] CFG_KEY_HIGH  = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_KEY_LOW   = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_DIRECTION = 2'd2;

	localparam int CfgDataW = 64;
	localparam int NumRounds = 32;
	localparam int RoundIdxW = $clog2(NumRounds);

	// Input and output words
	typedef struct packed {
		logic [63:0] block_high;
		logic [63:0] block_low;
	} blk_t;

	typedef struct packed {
		logic [63:0] result_high;
		logic [63:0] result_low;
	} res_t;

	// Controller to datapath commands
	typedef struct packed {
		logic                 load;
		logic                 expand;
		logic                 round;
		logic                 out_load;
		logic [RoundIdxW-1:0] idx;
	} sm4_cmd_t;

	localparam logic [31:0] FK0 = 32'hA3B1BAC6;
	localparam logic [31:0] FK1 = 32'h56AA3350;
	localparam logic [31:0] FK2 = 32'h677D9197;
	localparam logic [31:0] FK3 = 32'hB27022DC;

	localparam logic [31:0] CK_TAB [NumRounds] = '{
		32'h00070E15, 32'h1C232A31, 32'h383F464D, 32'h545B6269,
		32'h70777E85, 32'h8C939AA1, 32'hA8AFB6BD, 32'hC4CBD2D9,
		32'hE0E7EEF5, 32'hFC030A11, 32'h181F262D, 32'h343B4249,
		32'h50575E65, 32'h6C737A81, 32'h888F969D, 32'hA4ABB2B9,
		32'hC0C7CED5, 32'hDCE3EAF1, 32'hF8FF060D, 32'h141B2229,
		32'h30373E45, 32'h4C535A61, 32'h686F767D, 32'h848B9299,
		32'hA0A7AEB5, 32'hBCC3CAD1, 32'hD8DFE6ED, 32'hF4FB0209,
		32'h10171E25, 32'h2C333A41, 32'h484F565D, 32'h646B7279
	};

	localparam logic [7:0] SBOX [256] = '{
		8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
		8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
		8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
		8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
		8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
		8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
		8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
		8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
		8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
		8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
		8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
		8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
		8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
		8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
		8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
		8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
	};

	// Byte-wise S-box substitution
	function automatic logic [31:0] tau(input logic [31:0] v);
		return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
	endfunction

	// Data-path linear transform: rotations by 2, 10, 18, 24
	function automatic logic [31:0] lin_data(input logic [31:0] b);
		return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
			^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
	endfunction

	// Key-schedule linear transform: rotations by 13, 23
	function automatic logic [31:0] lin_key(input logic [31:0] b);
		return b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
	endfunction

endpackage

// File: rtl/sm4_block_cipher.sv
`timescale 1ns / 1ps
// SM4 block cipher top level: configuration registers, controller and datapath.
// Depends on sm4_pkg, sm4_ctrl and sm4_datapath.
//
//   channel | direction | handshake             | payload
//   blk     | in        | blk_valid / blk_ready | blk (block_high, block_low)
//   res     | out       | res_valid / res_ready | res (result_high, result_low)
//   cfg     | in        | cfg_we                | cfg_index, cfg_data
//
// A word runs from acceptance through 32 rounds in the single shared S-box round
// unit, then one output load, before blk_ready returns. After a write to a listed
// configuration register the next word first runs key expansion through the
// same unit. Reset clears the key and direction to zero and marks the round keys
// stale. A stalled output holds the result register; the next word is taken
// meanwhile and waits before loading.

module sm4_block_cipher (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 blk_valid,
	output logic                                 blk_ready,
	input  sm4_pkg::blk_t                        blk,
	output logic                                 res_valid,
	input  logic                                 res_ready,
	output sm4_pkg::res_t                        res,
	input  logic                                 cfg_we,
	input  logic [sm4_pkg::CfgIdxW-1:0]          cfg_index,
	input  logic [sm4_pkg::CfgDataW-1:0]         cfg_data
);

	logic [63:0]       key_high_q;
	logic [63:0]       key_low_q;
	logic              direction_q;
	logic              cfg_touch;
	logic              keys_ready;
	sm4_pkg::sm4_cmd_t cmd;

	// Decode register writes to listed indexes
	always_comb begin
		unique case (cfg_index)
			sm4_pkg::CFG_KEY_HIGH,
			sm4_pkg::CFG_KEY_LOW,
			sm4_pkg::CFG_DIRECTION: cfg_touch = cfg_we;
			default:                cfg_touch = 1'b0;
		endcase
	end

	// Hold key and direction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q  <= '0;
			key_low_q   <= '0;
			direction_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sm4_pkg::CFG_KEY_HIGH:  key_high_q  <= cfg_data;
				sm4_pkg::CFG_KEY_LOW:   key_low_q   <= cfg_data;
				sm4_pkg::CFG_DIRECTION: direction_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	sm4_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.blk_valid  (blk_valid),
		.blk_ready  (blk_ready),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.cfg_touch  (cfg_touch),
		.keys_ready (keys_ready),
		.cmd        (cmd)
	);

	sm4_datapath u_dp (
		.clk       (clk),
		.cmd       (cmd),
		.blk       (blk),
		.key_high  (key_high_q),
		.key_low   (key_low_q),
		.direction (direction_q),
		.res       (res)
	);

`ifndef SYNTHESIS
	// An accepted word closes the input until it is done
	assert property (@(posedge clk) disable iff (!arst_n)
		(blk_valid && blk_ready) |=> !blk_ready)
		else $error("input stayed open after accepting a word");

	// A write to a listed register leaves the round keys stale
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_touch |=> !keys_ready)
		else $error("round keys still marked ready after a register write");

	// Key expansion runs only while the round keys are stale
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.expand |-> !keys_ready)
		else $error("key expansion with ready round keys");

	// Only one datapath operation at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.expand, cmd.round, cmd.out_load}))
		else $error("conflicting datapath commands");
`endif

endmodule

// File: rtl/sm4_ctrl.sv
`timescale 1ns / 1ps
// SM4 controller: sequences key expansion, rounds and output load.
// Depends on sm4_pkg for the command struct and round count.

module sm4_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              blk_valid,
	output logic              blk_ready,
	output logic              res_valid,
	input  logic              res_ready,
	input  logic              cfg_touch,
	output logic              keys_ready,
	output sm4_pkg::sm4_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXPAND,
		ST_ROUND,
		ST_DRAIN
	} state_t;

	localparam logic [sm4_pkg::RoundIdxW-1:0] LastIdx =
		sm4_pkg::RoundIdxW'(sm4_pkg::NumRounds - 1);

	state_t                         state_q;
	logic [sm4_pkg::RoundIdxW-1:0]  cnt_q;
	logic                           keys_ready_q;
	logic                           res_valid_q;
	logic                           slot_free;

	assign slot_free = !res_valid_q || res_ready;

	// Decode commands from state
	always_comb begin
		cmd.load     = (state_q == ST_IDLE) && blk_valid;
		cmd.expand   = (state_q == ST_EXPAND);
		cmd.round    = (state_q == ST_ROUND);
		cmd.out_load = (state_q == ST_DRAIN) && slot_free;
		cmd.idx      = cnt_q;
	end

	assign blk_ready  = (state_q == ST_IDLE);
	assign res_valid  = res_valid_q;
	assign keys_ready = keys_ready_q;

	// Hold state, round counter, key status and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			keys_ready_q <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (blk_valid)
						state_q <= keys_ready_q ? ST_ROUND : ST_EXPAND;
				end
				ST_EXPAND: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LastIdx)
						state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LastIdx)
						state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (slot_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			// Raise output valid on a load, drop it once the word is taken
			if ((state_q == ST_DRAIN) && slot_free)
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;
			// Drop stale round keys on a write to a listed register
			if (cfg_touch)
				keys_ready_q <= 1'b0;
			else if ((state_q == ST_EXPAND) && (cnt_q == LastIdx))
				keys_ready_q <= 1'b1;
		end
	end

endmodule

// File: rtl/sm4_datapath.sv
`timescale 1ns / 1ps
// SM4 datapath: round-key store, shared S-box round unit, state and output words.
// Depends on sm4_pkg for tables, transforms and the command struct.

module sm4_datapath (
	input  logic              clk,
	input  sm4_pkg::sm4_cmd_t cmd,
	input  sm4_pkg::blk_t     blk,
	input  logic [63:0]       key_high,
	input  logic [63:0]       key_low,
	input  logic              direction,
	output sm4_pkg::res_t     res
);

	logic [31:0] x_q  [4];
	logic [31:0] k_q  [4];
	logic [31:0] rk_q [sm4_pkg::NumRounds];
	sm4_pkg::res_t res_q;

	logic [31:0] t_in;
	logic [31:0] t_out;
	logic [31:0] new_k;
	logic [31:0] new_x;
	logic [sm4_pkg::RoundIdxW-1:0] wr_idx;

	// Share one S-box unit between key schedule and rounds
	always_comb begin
		if (cmd.expand)
			t_in = k_q[1] ^ k_q[2] ^ k_q[3] ^ sm4_pkg::CK_TAB[cmd.idx];
		else
			t_in = x_q[1] ^ x_q[2] ^ x_q[3] ^ rk_q[cmd.idx];
		t_out = sm4_pkg::tau(t_in);
		new_k = k_q[0] ^ sm4_pkg::lin_key(t_out);
		new_x = x_q[0] ^ sm4_pkg::lin_data(t_out);
	end

	// Decryption stores round keys reversed: 31 - i is the bitwise inverse
	assign wr_idx = cmd.idx ^ {sm4_pkg::RoundIdxW{direction}};

	// Load block and key, advance key schedule, advance rounds, load output
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q[0] <= blk.block_high[63:32];
			x_q[1] <= blk.block_high[31:0];
			x_q[2] <= blk.block_low[63:32];
			x_q[3] <= blk.block_low[31:0];
			k_q[0] <= key_high[63:32] ^ sm4_pkg::FK0;
			k_q[1] <= key_high[31:0] ^ sm4_pkg::FK1;
			k_q[2] <= key_low[63:32] ^ sm4_pkg::FK2;
			k_q[3] <= key_low[31:0] ^ sm4_pkg::FK3;
		end
		if (cmd.expand) begin
			rk_q[wr_idx] <= new_k;
			k_q[0] <= k_q[1];
			k_q[1] <= k_q[2];
			k_q[2] <= k_q[3];
			k_q[3] <= new_k;
		end
		if (cmd.round) begin
			x_q[0] <= x_q[1];
			x_q[1] <= x_q[2];
			x_q[2] <= x_q[3];
			x_q[3] <= new_x;
		end
		// Emit final words in reversed order
		if (cmd.out_load) begin
			res_q.result_high <= {x_q[3], x_q[2]};
			res_q.result_low  <= {x_q[1], x_q[0]};
		end
	end

	assign res = res_q;

endmodule

// File: tb/sm4_block_cipher_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for sm4_block_cipher: a directed table of known-answer and corner
// words, then random keys, directions and words under random flow control on both sides.
// Depends on sm4_pkg for the port types and register indexes; carries its own SM4 model.

module sm4_block_cipher_tb;
	import sm4_pkg::*;

	localparam int LIMIT_CYCLES = 600_000;
	localparam int DRAIN_CYCLES = 80;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASES = 16;
	localparam int PHASE_WORDS = 47;
	localparam int PRESSURE_PHASE = 2;
	localparam logic [CfgIdxW-1:0] CFG_SPARE = 2'd3;

	// Standard known-answer pair: the key equals the plaintext
	localparam logic [63:0] KAT_PLAIN_HI = 64'h0123_4567_89ab_cdef;
	localparam logic [63:0] KAT_PLAIN_LO = 64'hfedc_ba98_7654_3210;
	localparam logic [63:0] KAT_CIPHER_HI = 64'h681e_df34_d206_965e;
	localparam logic [63:0] KAT_CIPHER_LO = 64'h86b3_e94f_536e_4246;

	localparam logic [31:0] SYS_PARAM [4] = '{
		32'hA3B1BAC6, 32'h56AA3350, 32'h677D9197, 32'hB27022DC
	};

	localparam logic [7:0] SUBST [256] = '{
		8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
		8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
		8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
		8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
		8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
		8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
		8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
		8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
		8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
		8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
		8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
		8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
		8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
		8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
		8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
		8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
	};

	typedef enum logic {ROW_REG, ROW_WORD} row_kind_e;
	typedef enum logic [1:0] {READY_ALWAYS, READY_COIN, READY_PERIODIC, READY_SPARSE} stall_e;

	typedef struct {
		row_kind_e            kind;
		logic [CfgIdxW-1:0]   idx;
		logic [63:0]          hi;
		logic [63:0]          lo;
		bit                   known;
		res_t                 want;
	} row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 blk_valid;
	logic                 blk_ready;
	blk_t                 blk;
	logic                 res_valid;
	logic                 res_ready = 1'b0;
	res_t                 res;
	logic                 cfg_we;
	logic [CfgIdxW-1:0]   cfg_index;
	logic [CfgDataW-1:0]  cfg_data;

	// Bench copy of the key state
	logic [63:0] m_key_high;
	logic [63:0] m_key_low;
	bit          m_decrypt;
	logic [31:0] m_round_keys [32];
	bit          m_keys_fresh;

	res_t   pending_outputs [$];
	row_t   plan [$];
	int     mismatches = 0;
	int     cycles = 0;
	int     burst_left = 0;
	bit     offering = 1'b0;
	bit     writing = 1'b0;
	bit     no_gaps = 1'b0;
	bit     hold_req = 1'b0;
	bit     hold_done = 1'b0;
	int     hold_left = 0;
	int     mode_left = 0;
	int     pattern_step = 0;
	stall_e stall_mode = READY_ALWAYS;

	sm4_block_cipher DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.blk_valid (blk_valid),
		.blk_ready (blk_ready),
		.blk       (blk),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [31:0] rotl(input logic [31:0] w, input int n);
		return (w << n) | (w >> (32 - n));
	endfunction

	function automatic logic [31:0] subst_word(input logic [31:0] w);
		return {SUBST[w[31:24]], SUBST[w[23:16]], SUBST[w[15:8]], SUBST[w[7:0]]};
	endfunction

	// Round constant byte j of round i is (4*i + j) * 7 mod 256
	function automatic logic [31:0] round_const(input int i);
		logic [31:0] c;
		c = '0;
		for (int j = 0; j < 4; j++)
			c = {c[23:0], 8'((4 * i + j) * 7)};
		return c;
	endfunction

	// Expand the current key; store the schedule reversed when decrypting
	function automatic void expand_round_keys();
		logic [31:0] k [4];
		logic [31:0] sched [32];
		logic [31:0] t;
		k[0] = m_key_high[63:32] ^ SYS_PARAM[0];
		k[1] = m_key_high[31:0] ^ SYS_PARAM[1];
		k[2] = m_key_low[63:32] ^ SYS_PARAM[2];
		k[3] = m_key_low[31:0] ^ SYS_PARAM[3];
		for (int i = 0; i < 32; i++) begin
			t = subst_word(k[1] ^ k[2] ^ k[3] ^ round_const(i));
			sched[i] = k[0] ^ t ^ rotl(t, 13) ^ rotl(t, 23);
			k[0] = k[1];
			k[1] = k[2];
			k[2] = k[3];
			k[3] = sched[i];
		end
		for (int i = 0; i < 32; i++)
			m_round_keys[i] = m_decrypt ? sched[31 - i] : sched[i];
		m_keys_fresh = 1'b1;
	endfunction

	// Run 32 rounds on one word and emit the last four round words reversed
	function automatic res_t crypt_word(input blk_t b);
		logic [31:0] x [4];
		logic [31:0] t;
		logic [31:0] nx;
		res_t r;
		if (!m_keys_fresh)
			expand_round_keys();
		x[0] = b.block_high[63:32];
		x[1] = b.block_high[31:0];
		x[2] = b.block_low[63:32];
		x[3] = b.block_low[31:0];
		for (int i = 0; i < 32; i++) begin
			t = subst_word(x[1] ^ x[2] ^ x[3] ^ m_round_keys[i]);
			nx = x[0] ^ t ^ rotl(t, 2) ^ rotl(t, 10) ^ rotl(t, 18) ^ rotl(t, 24);
			x[0] = x[1];
			x[1] = x[2];
			x[2] = x[3];
			x[3] = nx;
		end
		r.result_high = {x[3], x[2]};
		r.result_low = {x[1], x[0]};
		return r;
	endfunction

	// Mostly random, sometimes all zeros, all ones or a single bit
	function automatic logic [63:0] pick_word();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return 64'd1 << $urandom_range(0, 63);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic void add_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] data);
		row_t r;
		r = '{ROW_REG, idx, data, '0, 1'b0, '0};
		plan.push_back(r);
	endfunction

	function automatic void add_word(input logic [63:0] hi, input logic [63:0] lo);
		row_t r;
		r = '{ROW_WORD, CFG_KEY_HIGH, hi, lo, 1'b0, '0};
		plan.push_back(r);
	endfunction

	function automatic void add_known(input logic [63:0] hi, input logic [63:0] lo,
			input logic [63:0] want_hi, input logic [63:0] want_lo);
		row_t r;
		r = '{ROW_WORD, CFG_KEY_HIGH, hi, lo, 1'b1, {want_hi, want_lo}};
		plan.push_back(r);
	endfunction

	// Drop valid and wait until every accepted word has come back
	task automatic drain();
		if (offering) begin
			blk_valid <= 1'b0;
			offering = 1'b0;
		end
		while (pending_outputs.size() != 0)
			@(posedge clk);
	endtask

	// Write one register while the block is idle and mirror it in the model
	task automatic reg_write(input logic [CfgIdxW-1:0] idx, input logic [63:0] data);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		writing = 1'b1;
		case (idx)
			CFG_KEY_HIGH: begin
				m_key_high = data;
				m_keys_fresh = 1'b0;
			end
			CFG_KEY_LOW: begin
				m_key_low = data;
				m_keys_fresh = 1'b0;
			end
			CFG_DIRECTION: begin
				m_decrypt = data[0];
				m_keys_fresh = 1'b0;
			end
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Offer one word, record its expected result, then maybe idle after the burst
	task automatic offer_word(input blk_t b, input bit known, input res_t want);
		res_t p;
		int gap;
		if (writing) begin
			cfg_we <= 1'b0;
			writing = 1'b0;
		end
		blk_valid <= 1'b1;
		blk <= b;
		offering = 1'b1;
		@(posedge clk);
		while (!blk_ready)
			@(posedge clk);
		p = crypt_word(b);
		if (known && p !== want) begin
			mismatches++;
			$display("%0t: model disagrees with known answer: expected %h, model %h",
				$time, want, p);
		end
		pending_outputs.push_back(known ? want : p);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 15);
			gap = no_gaps ? 0 : $urandom_range(0, 70);
			if (gap != 0) begin
				blk_valid <= 1'b0;
				offering = 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Receiver: a long hold when asked, otherwise a stall pattern that changes now and then
	always @(posedge clk) begin
		pattern_step++;
		if (hold_left != 0) begin
			hold_left--;
			res_ready <= 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES - 1;
			res_ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				stall_mode = stall_e'($urandom_range(0, 3));
				mode_left = $urandom_range(50, 400);
			end else begin
				mode_left--;
			end
			case (stall_mode)
				READY_ALWAYS: res_ready <= 1'b1;
				READY_COIN: res_ready <= 1'($urandom_range(0, 1));
				READY_PERIODIC: res_ready <= (pattern_step % 7) < 2;
				default: res_ready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	// Check each accepted result against the oldest expectation
	always @(posedge clk) begin : check_results
		res_t want;
		if (res_valid && res_ready) begin
			if (pending_outputs.size() == 0) begin
				mismatches++;
				$display("%0t: result with nothing expected: expected none, got %h", $time, res);
			end else begin
				want = pending_outputs.pop_front();
				if (res.result_high !== want.result_high) begin
					mismatches++;
					$display("%0t: result_high mismatch: expected %h, got %h",
						$time, want.result_high, res.result_high);
				end
				if (res.result_low !== want.result_low) begin
					mismatches++;
					$display("%0t: result_low mismatch: expected %h, got %h",
						$time, want.result_low, res.result_low);
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles == LIMIT_CYCLES) begin
			$display("%0t: timeout with %0d results outstanding", $time, pending_outputs.size());
			$display("sm4_block_cipher_tb: FAIL");
			$finish;
		end
	end

	initial begin
		blk_t b;
		res_t want;

		arst_n = 1'b0;
		blk_valid = 1'b0;
		blk = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_KEY_HIGH;
		cfg_data = '0;
		m_key_high = '0;
		m_key_low = '0;
		m_decrypt = 1'b0;
		m_keys_fresh = 1'b0;

		// Reset key (all zero, encrypt): extremes of the word fields
		add_word('0, '0);
		add_word('1, '1);
		add_word(64'h8000_0000_0000_0000, '0);
		add_word('0, 64'h1);
		// Standard key, encrypt; second word reuses the schedule
		add_reg(CFG_KEY_HIGH, KAT_PLAIN_HI);
		add_reg(CFG_KEY_LOW, KAT_PLAIN_LO);
		add_reg(CFG_DIRECTION, '0);
		add_known(KAT_PLAIN_HI, KAT_PLAIN_LO, KAT_CIPHER_HI, KAT_CIPHER_LO);
		add_known(KAT_PLAIN_HI, KAT_PLAIN_LO, KAT_CIPHER_HI, KAT_CIPHER_LO);
		// Rewriting the same key value forces a fresh expansion
		add_reg(CFG_KEY_HIGH, KAT_PLAIN_HI);
		add_known(KAT_PLAIN_HI, KAT_PLAIN_LO, KAT_CIPHER_HI, KAT_CIPHER_LO);
		// Decrypt with reversed schedule
		add_reg(CFG_DIRECTION, 64'h1);
		add_known(KAT_CIPHER_HI, KAT_CIPHER_LO, KAT_PLAIN_HI, KAT_PLAIN_LO);
		add_word('0, '0);
		add_word('1, '1);
		// Unlisted register index changes nothing
		add_reg(CFG_SPARE, '1);
		add_known(KAT_CIPHER_HI, KAT_CIPHER_LO, KAT_PLAIN_HI, KAT_PLAIN_LO);
		// Only bit 0 of direction counts
		add_reg(CFG_DIRECTION, 64'hFFFF_FFFF_FFFF_FFFE);
		add_known(KAT_PLAIN_HI, KAT_PLAIN_LO, KAT_CIPHER_HI, KAT_CIPHER_LO);
		add_reg(CFG_DIRECTION, '1);
		add_known(KAT_CIPHER_HI, KAT_CIPHER_LO, KAT_PLAIN_HI, KAT_PLAIN_LO);
		// All-ones key both ways
		add_reg(CFG_KEY_HIGH, '1);
		add_reg(CFG_KEY_LOW, '1);
		add_reg(CFG_DIRECTION, '0);
		add_word('0, '0);
		add_word('1, '1);
		add_reg(CFG_DIRECTION, 64'h1);
		add_word('0, '0);
		add_word('1, '1);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Walk the directed table
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_REG) begin
				reg_write(plan[i].idx, plan[i].hi);
			end else begin
				b.block_high = plan[i].hi;
				b.block_low = plan[i].lo;
				offer_word(b, plan[i].known, plan[i].want);
			end
		end

		// Random phases: new settings between phases, random words within
		want = '0;
		for (int ph = 0; ph < PHASES; ph++) begin
			no_gaps = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 1))
				reg_write(CFG_KEY_HIGH, pick_word());
			if ($urandom_range(0, 1))
				reg_write(CFG_KEY_LOW, pick_word());
			if ($urandom_range(0, 1))
				reg_write(CFG_DIRECTION, {$urandom, $urandom});
			if ($urandom_range(0, 5) == 0)
				reg_write(CFG_SPARE, {$urandom, $urandom});
			// Hold the output off so the block backs up into its input
			if (ph == PRESSURE_PHASE)
				hold_req = 1'b1;
			for (int n = 0; n < PHASE_WORDS; n++) begin
				b.block_high = pick_word();
				b.block_low = pick_word();
				offer_word(b, 1'b0, want);
			end
		end

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("sm4_block_cipher_tb: PASS");
		else
			$display("sm4_block_cipher_tb: FAIL");
		$finish;
	end

endmodule
